// File: rtl/rci_pkg.sv
// Shared types, widths and register indices for the ray and circle intersection block.
package rci_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DirW = 16;
  localparam int unsigned RadW = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RootW = 32;
  localparam int unsigned RadicandW = 64;
  localparam int unsigned QuotW = 17;
  localparam int unsigned DivDenW = 31;

  localparam logic [CfgIdxW-1:0] RegCenterX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRadius = 2'd2;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
  } ray_in_t;

  typedef struct packed {
    logic hit;
    logic signed [CoordW-1:0] hit_distance;
    logic signed [DirW-1:0] normal_x;
    logic signed [DirW-1:0] normal_y;
  } ray_out_t;

  // Integer square root, one result bit per cell.
  typedef struct packed {
    logic [RadicandW-1:0] rem;
    logic [RootW-1:0] root;
  } sqrt_cell_t;

  // Restoring division, one quotient bit per cell.
  typedef struct packed {
    logic [DivDenW+QuotW:0] rem;
    logic [QuotW-1:0] quot;
  } div_cell_t;

endpackage

// File: rtl/rci_sqrt_cell.sv
// One stage of a bit-serial integer square root chain, with a payload carried alongside.
module rci_sqrt_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned PayW = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  rci_pkg::sqrt_cell_t dat_i,
  input  logic [PayW-1:0] pay_i,
  output logic vld_o,
  output rci_pkg::sqrt_cell_t dat_o,
  output logic [PayW-1:0] pay_o
);
  // The root bit decided here is bit (RootW-1-Step).
  localparam int unsigned Bit = rci_pkg::RootW - 1 - Step;

  logic [rci_pkg::RadicandW+1:0] trial;
  logic [rci_pkg::RadicandW+1:0] rem_w;
  rci_pkg::sqrt_cell_t dat_nxt;
  rci_pkg::sqrt_cell_t dat_r;
  logic [PayW-1:0] pay_r;
  logic vld_r;

  always_comb begin
    trial = ({34'd0, dat_i.root} << (Bit + 1)) + (66'd1 << (2 * Bit));
    rem_w = {2'b00, dat_i.rem};
    dat_nxt = dat_i;
    if (rem_w >= trial) begin
      dat_nxt.rem = rem_w[rci_pkg::RadicandW-1:0] - trial[rci_pkg::RadicandW-1:0];
      dat_nxt.root[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    dat_r <= dat_nxt;
    pay_r <= pay_i;
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;
  assign pay_o = pay_r;
endmodule

// File: rtl/rci_div_cell.sv
// One stage of a restoring divider chain, with a payload carried alongside.
module rci_div_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned PayW = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic vld_i,
  input  rci_pkg::div_cell_t dat_i,
  input  logic [rci_pkg::DivDenW-1:0] den_i,
  input  logic [PayW-1:0] pay_i,
  output logic vld_o,
  output rci_pkg::div_cell_t dat_o,
  output logic [rci_pkg::DivDenW-1:0] den_o,
  output logic [PayW-1:0] pay_o
);
  localparam int unsigned Bit = rci_pkg::QuotW - 1 - Step;
  localparam int unsigned RemW = rci_pkg::DivDenW + rci_pkg::QuotW + 1;

  logic [RemW-1:0] shd;
  rci_pkg::div_cell_t dat_nxt;
  rci_pkg::div_cell_t dat_r;
  logic [rci_pkg::DivDenW-1:0] den_r;
  logic [PayW-1:0] pay_r;
  logic vld_r;

  always_comb begin
    shd = {{(rci_pkg::QuotW + 1){1'b0}}, den_i} << Bit;
    dat_nxt = dat_i;
    if (dat_i.rem >= shd) begin
      dat_nxt.rem = dat_i.rem - shd;
      dat_nxt.quot[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    dat_r <= dat_nxt;
    den_r <= den_i;
    pay_r <= pay_i;
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;
  assign den_o = den_r;
  assign pay_o = pay_r;
endmodule

// File: rtl/ray_circle_intersection_top.sv
// Top level of the ray and circle intersection pipeline.
//
// Usage: load the circle center and radius through the cfg_ write port while the
// block is idle, then pulse in_start with one ray per cycle. The block never
// raises in_busy, so a ray transaction is accepted at every clock edge at which
// in_start is high. Each ray produces exactly one result transaction, shown on
// out_data for one cycle with out_strobe high; the receiver cannot stall it.
// Throughput is one ray per cycle. The pipeline depth is set by the chains of
// cells: a 32-cell square root for the chord half length, a 32-cell square
// root for the normal length and two 17-cell dividers running side by side,
// plus the multiply and add stages around them.
// Each cell decides one result bit and passes its partial remainder on to the
// next cell every cycle, so many rays are in flight at once.
// Synchronous reset clears the configuration registers and all valid bits; rays
// in flight at reset are dropped. A miss gives all result fields zero.
module ray_circle_intersection_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_start,
  output logic in_busy,
  input  rci_pkg::ray_in_t in_data,
  input  logic cfg_we,
  input  logic [rci_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [rci_pkg::CoordW-1:0] cfg_wdata,
  output logic out_strobe,
  output rci_pkg::ray_out_t out_data
);
  localparam int unsigned NSq = rci_pkg::RootW;
  localparam int unsigned NDv = rci_pkg::QuotW;

  // Configuration registers.
  logic signed [31:0] cx_r, cy_r;
  logic [30:0] rad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0;
      cy_r <= '0;
      rad_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rci_pkg::RegCenterX: cx_r <= cfg_wdata;
        rci_pkg::RegCenterY: cy_r <= cfg_wdata;
        rci_pkg::RegRadius: rad_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign in_busy = 1'b0;

  // Stage 1: offset from ray start to center.
  logic v1_r;
  logic signed [32:0] dlx_r, dly_r;
  logic signed [31:0] sx1_r, sy1_r;
  logic signed [15:0] dx1_r, dy1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_start;
    dlx_r <= 33'(cx_r) - 33'(in_data.start_x);
    dly_r <= 33'(cy_r) - 33'(in_data.start_y);
    sx1_r <= in_data.start_x;
    sy1_r <= in_data.start_y;
    dx1_r <= in_data.dir_x;
    dy1_r <= in_data.dir_y;
  end

  // Stage 2: projection products.
  logic v2_r;
  logic signed [48:0] px_r, py_r;
  logic signed [32:0] dlx2_r, dly2_r;
  logic signed [31:0] sx2_r, sy2_r;
  logic signed [15:0] dx2_r, dy2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    px_r <= 49'(dlx_r) * 49'(dx1_r);
    py_r <= 49'(dly_r) * 49'(dy1_r);
    dlx2_r <= dlx_r; dly2_r <= dly_r;
    sx2_r <= sx1_r; sy2_r <= sy1_r;
    dx2_r <= dx1_r; dy2_r <= dy1_r;
  end

  // Stage 3: projection sum, behind test, proj = p >> 15.
  logic signed [49:0] p_w;
  assign p_w = 50'(px_r) + 50'(py_r);
  logic v3_r, m3_r;
  logic signed [34:0] proj_r;
  logic signed [32:0] dlx3_r, dly3_r;
  logic signed [31:0] sx3_r, sy3_r;
  logic signed [15:0] dx3_r, dy3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
    m3_r <= p_w[49];
    proj_r <= p_w[49:15];
    dlx3_r <= dlx2_r; dly3_r <= dly2_r;
    sx3_r <= sx2_r; sy3_r <= sy2_r;
    dx3_r <= dx2_r; dy3_r <= dy2_r;
  end

  // Stage 4: proj * dir.
  logic v4_r, m4_r;
  logic signed [50:0] qx4_r, qy4_r;
  logic signed [34:0] proj4_r;
  logic signed [32:0] dlx4_r, dly4_r;
  logic signed [31:0] sx4_r, sy4_r;
  logic signed [15:0] dx4_r, dy4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
    m4_r <= m3_r;
    qx4_r <= 51'(proj_r) * 51'(dx3_r);
    qy4_r <= 51'(proj_r) * 51'(dy3_r);
    proj4_r <= proj_r;
    dlx4_r <= dlx3_r; dly4_r <= dly3_r;
    sx4_r <= sx3_r; sy4_r <= sy3_r;
    dx4_r <= dx3_r; dy4_r <= dy3_r;
  end

  // Stage 5: perpendicular offset e and range check.
  logic signed [36:0] ex_w, ey_w;
  assign ex_w = 37'(dlx4_r) - 37'($signed(qx4_r[50:15]));
  assign ey_w = 37'(dly4_r) - 37'($signed(qy4_r[50:15]));
  logic [36:0] aex_w, aey_w;
  assign aex_w = ex_w[36] ? 37'(-ex_w) : 37'(ex_w);
  assign aey_w = ey_w[36] ? 37'(-ey_w) : 37'(ey_w);
  logic v5_r, m5_r;
  logic [30:0] aex_r, aey_r;
  logic signed [34:0] proj5_r;
  logic signed [31:0] sx5_r, sy5_r;
  logic signed [15:0] dx5_r, dy5_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
    m5_r <= m4_r || (aex_w[36:31] != '0) || (aey_w[36:31] != '0);
    aex_r <= aex_w[30:0];
    aey_r <= aey_w[30:0];
    proj5_r <= proj4_r;
    sx5_r <= sx4_r; sy5_r <= sy4_r;
    dx5_r <= dx4_r; dy5_r <= dy4_r;
  end

  // Stage 6: squares.
  logic v6_r, m6_r;
  logic [61:0] ex2_r, ey2_r, r2_r;
  logic signed [34:0] proj6_r;
  logic signed [31:0] sx6_r, sy6_r;
  logic signed [15:0] dx6_r, dy6_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
    m6_r <= m5_r;
    ex2_r <= 62'(aex_r) * 62'(aex_r);
    ey2_r <= 62'(aey_r) * 62'(aey_r);
    r2_r <= 62'(rad_r) * 62'(rad_r);
    proj6_r <= proj5_r;
    sx6_r <= sx5_r; sy6_r <= sy5_r;
    dx6_r <= dx5_r; dy6_r <= dy5_r;
  end

  // Stage 7: d2 compare and radicand.
  logic [63:0] d2_w, rdiff_w;
  assign d2_w = 64'(ex2_r) + 64'(ey2_r);
  assign rdiff_w = 64'(r2_r) - d2_w;
  localparam int unsigned PayAW = 1 + 35 + 32 + 32 + 16 + 16;
  logic v7_r;
  rci_pkg::sqrt_cell_t sq7_r;
  logic [PayAW-1:0] pa7_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else v7_r <= v6_r;
    sq7_r.rem <= rdiff_w;
    sq7_r.root <= '0;
    pa7_r <= {m6_r || (d2_w > 64'(r2_r)), proj6_r, sx6_r, sy6_r, dx6_r, dy6_r};
  end

  // Square root chain for the half chord.
  logic sav [NSq+1];
  rci_pkg::sqrt_cell_t sad [NSq+1];
  logic [PayAW-1:0] sap [NSq+1];
  assign sav[0] = v7_r;
  assign sad[0] = sq7_r;
  assign sap[0] = pa7_r;
  for (genvar g = 0; g < NSq; g++) begin : g_sqa
    rci_sqrt_cell #(.Step(g), .PayW(PayAW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(sav[g]), .dat_i(sad[g]), .pay_i(sap[g]),
      .vld_o(sav[g+1]), .dat_o(sad[g+1]), .pay_o(sap[g+1])
    );
  end

  // Unpack and compute t.
  logic ma_w;
  logic signed [34:0] proja_w;
  logic signed [31:0] sxa_w, sya_w;
  logic signed [15:0] dxa_w, dya_w;
  assign {ma_w, proja_w, sxa_w, sya_w, dxa_w, dya_w} = sap[NSq];
  logic va_r, ma_r;
  logic signed [35:0] t_r;
  logic signed [31:0] sxa_r, sya_r;
  logic signed [15:0] dxa_r, dya_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else va_r <= sav[NSq];
    ma_r <= ma_w;
    t_r <= 36'(proja_w) - 36'({1'b0, sad[NSq].root});
    sxa_r <= sxa_w; sya_r <= sya_w;
    dxa_r <= dxa_w; dya_r <= dya_w;
  end

  // t * dir.
  logic vb_r, mb_r;
  logic signed [51:0] tdx_r, tdy_r;
  logic signed [35:0] tb_r;
  logic signed [31:0] sxb_r, syb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else vb_r <= va_r;
    mb_r <= ma_r;
    tdx_r <= 52'(t_r) * 52'(dxa_r);
    tdy_r <= 52'(t_r) * 52'(dya_r);
    tb_r <= t_r;
    sxb_r <= sxa_r; syb_r <= sya_r;
  end

  // Normal vector n = start + t*dir - center.
  logic signed [38:0] nx_w, ny_w;
  assign nx_w = 39'(sxb_r) + 39'($signed(tdx_r[51:15])) - 39'(cx_r);
  assign ny_w = 39'(syb_r) + 39'($signed(tdy_r[51:15])) - 39'(cy_r);
  logic vc_r, mc_r, snx_r, sny_r;
  logic [38:0] ux_r, uy_r;
  logic signed [35:0] tc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else vc_r <= vb_r;
    mc_r <= mb_r;
    snx_r <= nx_w[38];
    sny_r <= ny_w[38];
    ux_r <= nx_w[38] ? 39'(-nx_w) : 39'(nx_w);
    uy_r <= ny_w[38] ? 39'(-ny_w) : 39'(ny_w);
    tc_r <= tb_r;
  end

  // Common shift so both magnitudes drop below 2^30.
  logic [38:0] orv_w;
  logic [3:0] sh_w;
  assign orv_w = ux_r | uy_r;
  always_comb begin
    sh_w = '0;
    for (int k = 0; k < 9; k++) begin
      if (orv_w[30+k]) sh_w = 4'(k + 1);
    end
  end
  logic vd_r, md_r, snxd_r, snyd_r;
  logic [29:0] ax_r, ay_r;
  logic signed [35:0] td_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else vd_r <= vc_r;
    md_r <= mc_r;
    snxd_r <= snx_r; snyd_r <= sny_r;
    ax_r <= 30'(ux_r >> sh_w);
    ay_r <= 30'(uy_r >> sh_w);
    td_r <= tc_r;
  end

  // Squared length.
  localparam int unsigned PayBW = 1 + 1 + 1 + 36 + 30 + 30;
  logic ve_r;
  rci_pkg::sqrt_cell_t sqe_r;
  logic [PayBW-1:0] pbe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else ve_r <= vd_r;
    sqe_r.rem <= 64'(60'(ax_r) * 60'(ax_r)) + 64'(60'(ay_r) * 60'(ay_r));
    sqe_r.root <= '0;
    pbe_r <= {md_r, snxd_r, snyd_r, td_r, ax_r, ay_r};
  end

  // Square root chain for the normal length.
  logic sbv [NSq+1];
  rci_pkg::sqrt_cell_t sbd [NSq+1];
  logic [PayBW-1:0] sbp [NSq+1];
  assign sbv[0] = ve_r;
  assign sbd[0] = sqe_r;
  assign sbp[0] = pbe_r;
  for (genvar g = 0; g < NSq; g++) begin : g_sqb
    rci_sqrt_cell #(.Step(g), .PayW(PayBW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .vld_i(sbv[g]), .dat_i(sbd[g]), .pay_i(sbp[g]),
      .vld_o(sbv[g+1]), .dat_o(sbd[g+1]), .pay_o(sbp[g+1])
    );
  end

  logic mf_w, snxf_w, snyf_w;
  logic signed [35:0] tf_w;
  logic [29:0] axf_w, ayf_w;
  assign {mf_w, snxf_w, snyf_w, tf_w, axf_w, ayf_w} = sbp[NSq];

  // Two divider chains side by side, sharing the side payload on the x chain.
  localparam int unsigned PayCW = 1 + 1 + 1 + 1 + 36;
  localparam int unsigned DRemW = rci_pkg::DivDenW + rci_pkg::QuotW + 1;
  logic dxv [NDv+1];
  logic dyv [NDv+1];
  rci_pkg::div_cell_t dxd [NDv+1];
  rci_pkg::div_cell_t dyd [NDv+1];
  logic [rci_pkg::DivDenW-1:0] dxn [NDv+1];
  logic [rci_pkg::DivDenW-1:0] dyn [NDv+1];
  logic [PayCW-1:0] dxp [NDv+1];
  logic dyp [NDv+1];
  assign dxv[0] = sbv[NSq];
  assign dyv[0] = sbv[NSq];
  assign dxd[0].rem = DRemW'({axf_w, 15'd0});
  assign dxd[0].quot = '0;
  assign dyd[0].rem = DRemW'({ayf_w, 15'd0});
  assign dyd[0].quot = '0;
  assign dxn[0] = sbd[NSq].root[rci_pkg::DivDenW-1:0];
  assign dyn[0] = sbd[NSq].root[rci_pkg::DivDenW-1:0];
  assign dxp[0] = {mf_w, snxf_w, snyf_w, (sbd[NSq].root == '0), tf_w};
  assign dyp[0] = 1'b0;
  for (genvar g = 0; g < NDv; g++) begin : g_div
    rci_div_cell #(.Step(g), .PayW(PayCW)) u_dx (
      .clk(clk), .rst_n(rst_n),
      .vld_i(dxv[g]), .dat_i(dxd[g]), .den_i(dxn[g]), .pay_i(dxp[g]),
      .vld_o(dxv[g+1]), .dat_o(dxd[g+1]), .den_o(dxn[g+1]), .pay_o(dxp[g+1])
    );
    rci_div_cell #(.Step(g), .PayW(1)) u_dy (
      .clk(clk), .rst_n(rst_n),
      .vld_i(dyv[g]), .dat_i(dyd[g]), .den_i(dyn[g]), .pay_i(dyp[g]),
      .vld_o(dyv[g+1]), .dat_o(dyd[g+1]), .den_o(dyn[g+1]), .pay_o(dyp[g+1])
    );
  end

  // Sign, saturation and miss zeroing.
  logic mo_w, sxo_w, syo_w, z_w;
  logic signed [35:0] to_w;
  assign {mo_w, sxo_w, syo_w, z_w, to_w} = dxp[NDv];

  function automatic logic [15:0] sgn_sat(input logic neg, input logic [16:0] q);
    logic [16:0] r;
    begin
      r = q;
      if (neg) begin
        r = (q > 17'd32768) ? 17'h18000 : 17'(-q);
      end else if (q > 17'd32767) begin
        r = 17'd32767;
      end
      sgn_sat = r[15:0];
    end
  endfunction

  logic os_r;
  rci_pkg::ray_out_t od_r, od_nxt;
  always_comb begin
    od_nxt = '0;
    if (!mo_w) begin
      od_nxt.hit = 1'b1;
      if (to_w > 36'sd2147483647) od_nxt.hit_distance = 32'h7fffffff;
      else if (to_w < -36'sd2147483648) od_nxt.hit_distance = 32'h80000000;
      else od_nxt.hit_distance = to_w[31:0];
      if (!z_w) begin
        od_nxt.normal_x = sgn_sat(sxo_w, dxd[NDv].quot);
        od_nxt.normal_y = sgn_sat(syo_w, dyd[NDv].quot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) os_r <= 1'b0;
    else os_r <= dxv[NDv];
    od_r <= od_nxt;
  end

  assign out_strobe = os_r;
  assign out_data = od_r;

  // Both divider chains must stay in lockstep.
  a_div_lock: assert property (@(posedge clk) disable iff (!rst_n) dxv[NDv] == dyv[NDv])
    else $error("divider chains out of step");
  // A miss must not report a distance or an x normal component.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.hit |-> out_data.hit_distance == '0 && out_data.normal_x == '0)
    else $error("miss with nonzero fields");
  // A ray valid at stage 7 reaches the output after a fixed latency.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r |-> ##(NSq + NSq + NDv + 6) out_strobe)
    else $error("result lost in pipeline");
endmodule
